// ===== rtl/dfmc_pkg.sv =====
package dfmc_pkg;

  localparam int RAW_W   = 16;
  localparam int ABS_W   = RAW_W + 1;
  localparam int SENS_W  = 24;
  localparam int MAG_W   = 29;
  localparam int FRAC_SH = 12;
  localparam int PROD_W  = ABS_W + SENS_W;
  localparam int SCL_W   = 28;
  localparam int SUM_W   = 2 * SCL_W;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = MAG_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int SQRT_STAGES    = ROOT_W / BITS_PER_STAGE;

  localparam logic [SENS_W-1:0] SENS_X_RST = 24'd9830;
  localparam logic [SENS_W-1:0] SENS_Y_RST = 24'd9830;
  localparam logic [SENS_W-1:0] SENS_Z_RST = 24'd15859;
  localparam logic [MAG_W-1:0]  HIGH_RST   = 29'd8000;
  localparam logic [MAG_W-1:0]  MISM_RST   = 29'd4000;

  typedef enum logic [IDX_W-1:0] {
    REG_SENS_X   = 3'd0,
    REG_SENS_Y   = 3'd1,
    REG_SENS_Z   = 3'd2,
    REG_HIGH_LIM = 3'd3,
    REG_MISM_LIM = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] ref1_x;
    logic signed [RAW_W-1:0] ref1_y;
    logic signed [RAW_W-1:0] ref1_z;
    logic signed [RAW_W-1:0] ref2_x;
    logic signed [RAW_W-1:0] ref2_y;
    logic signed [RAW_W-1:0] ref2_z;
    logic [1:0]              valid_mask;
  } sample_t;

  typedef struct packed {
    logic [MAG_W-1:0] ref1_magnitude;
    logic [MAG_W-1:0] ref2_magnitude;
    logic [MAG_W-1:0] magnitude_gap;
    logic             data_invalid;
    logic             ref1_high;
    logic             ref2_high;
    logic             mismatch;
  } result_t;

  // one root in flight: radicand bits still to consume, partial remainder and root
  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

endpackage

// ===== rtl/dual_field_magnitude_check.sv =====
// path: a transaction accepted while busy is low passes through stages a, b and c, the
//   sum stage, the square root stages and stage d; the output register then raises done
// throughput: one transaction per cycle, set by the 14-stage square root pipeline
//   retiring two root bits per stage; the receiver cannot stall
// reset: synchronous rst clears all stage valids and loads register defaults;
//   busy is high while rst is high and low otherwise
module dual_field_magnitude_check
  import dfmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sample_t           sample,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [DATA_W-1:0] wr_data,
  output logic              done,
  output result_t           result
);

  logic [SENS_W-1:0] sens_x, sens_y, sens_z;
  logic [MAG_W-1:0]  high_field_limit, mismatch_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_x           <= SENS_X_RST;
      sens_y           <= SENS_Y_RST;
      sens_z           <= SENS_Z_RST;
      high_field_limit <= HIGH_RST;
      mismatch_limit   <= MISM_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_SENS_X:   sens_x           <= wr_data[SENS_W-1:0];
        REG_SENS_Y:   sens_y           <= wr_data[SENS_W-1:0];
        REG_SENS_Z:   sens_z           <= wr_data[SENS_W-1:0];
        REG_HIGH_LIM: high_field_limit <= wr_data[MAG_W-1:0];
        REG_MISM_LIM: mismatch_limit   <= wr_data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [ABS_W-1:0] abs_raw(logic [RAW_W-1:0] raw);
    logic [ABS_W-1:0] ext;
    ext = {raw[RAW_W-1], raw};
    return raw[RAW_W-1] ? (ABS_W'(0) - ext) : ext;
  endfunction

  function automatic logic [SCL_W-1:0] scale(logic [ABS_W-1:0] a, logic [SENS_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(s);
    return p[FRAC_SH +: SCL_W];
  endfunction

  // one restoring digit step: two radicand bits in, one root bit out
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] sub;
    sqrt_t o;
    trial = {s.rem, s.rad[SUM_W-1 -: 2]};
    sub   = (REM_W+2)'({s.root, 2'b01});
    o.rad = s.rad << 2;
    if (trial >= sub) begin
      o.rem  = REM_W'(trial - sub);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = trial[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // stage a: absolute values
  logic             a_v, a_inv;
  logic [ABS_W-1:0] a_abs [6];

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else     a_v <= accept;
    a_inv    <= sample.valid_mask != 2'b11;
    a_abs[0] <= abs_raw(sample.ref1_x);
    a_abs[1] <= abs_raw(sample.ref1_y);
    a_abs[2] <= abs_raw(sample.ref1_z);
    a_abs[3] <= abs_raw(sample.ref2_x);
    a_abs[4] <= abs_raw(sample.ref2_y);
    a_abs[5] <= abs_raw(sample.ref2_z);
  end

  // stage b: sensitivity scaling to 1/16 uT
  logic             b_v, b_inv;
  logic [SCL_W-1:0] b_scl [6];

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else     b_v <= a_v;
    b_inv    <= a_inv;
    b_scl[0] <= scale(a_abs[0], sens_x);
    b_scl[1] <= scale(a_abs[1], sens_y);
    b_scl[2] <= scale(a_abs[2], sens_z);
    b_scl[3] <= scale(a_abs[3], sens_x);
    b_scl[4] <= scale(a_abs[4], sens_y);
    b_scl[5] <= scale(a_abs[5], sens_z);
  end

  // stage c: squares
  logic             c_v, c_inv;
  logic [SUM_W-1:0] c_sq [6];

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else     c_v <= b_v;
    c_inv <= b_inv;
    for (int i = 0; i < 6; i++) begin
      c_sq[i] <= SUM_W'(b_scl[i]) * SUM_W'(b_scl[i]);
    end
  end

  // sqrt pipeline, index 0 is the sum stage
  logic  sq_v   [SQRT_STAGES+1];
  logic  sq_inv [SQRT_STAGES+1];
  sqrt_t sq1    [SQRT_STAGES+1];
  sqrt_t sq2    [SQRT_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= c_v;
    sq_inv[0]   <= c_inv;
    sq1[0].rad  <= c_sq[0] + c_sq[1] + c_sq[2];
    sq1[0].rem  <= '0;
    sq1[0].root <= '0;
    sq2[0].rad  <= c_sq[3] + c_sq[4] + c_sq[5];
    sq2[0].rem  <= '0;
    sq2[0].root <= '0;
  end

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) sq_v[g+1] <= 1'b0;
      else     sq_v[g+1] <= sq_v[g];
      sq_inv[g+1] <= sq_inv[g];
      sq1[g+1]    <= sqrt_step(sqrt_step(sq1[g]));
      sq2[g+1]    <= sqrt_step(sqrt_step(sq2[g]));
    end
  end

  // stage d: gap and high flags; a root is at most 28 bits so it never saturates
  logic             d_v, d_inv, d_high1, d_high2;
  logic [MAG_W-1:0] d_m1, d_m2, d_gap;
  logic [MAG_W-1:0] m1, m2;

  assign m1 = MAG_W'(sq1[SQRT_STAGES].root);
  assign m2 = MAG_W'(sq2[SQRT_STAGES].root);

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else     d_v <= sq_v[SQRT_STAGES];
    d_inv   <= sq_inv[SQRT_STAGES];
    d_m1    <= m1;
    d_m2    <= m2;
    d_gap   <= (m1 >= m2) ? (m1 - m2) : (m2 - m1);
    d_high1 <= m1 >= high_field_limit;
    d_high2 <= m2 >= high_field_limit;
  end

  // output register, invalid transactions force everything but the flag to zero
  result_t result_next;

  always_comb begin
    result_next.ref1_magnitude = d_inv ? '0 : d_m1;
    result_next.ref2_magnitude = d_inv ? '0 : d_m2;
    result_next.magnitude_gap  = d_inv ? '0 : d_gap;
    result_next.data_invalid   = d_inv;
    result_next.ref1_high      = !d_inv && d_high1;
    result_next.ref2_high      = !d_inv && d_high2;
    result_next.mismatch       = !d_inv && (d_gap >= mismatch_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= d_v;
    result <= result_next;
  end

endmodule

// ===== rtl/dfmc_checker.sv =====
module dfmc_checker
  import dfmc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input sample_t           sample,
  input logic              done,
  input result_t           result
);

  localparam int LATENCY = 20;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("transaction accepted but no result after latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.data_invalid |->
      result.ref1_magnitude == '0 && result.ref2_magnitude == '0 &&
      result.magnitude_gap == '0 && !result.ref1_high && !result.ref2_high &&
      !result.mismatch)
    else $error("invalid transaction carries nonzero fields");

  a_gap_consistent: assert property (@(posedge clk) disable iff (rst)
    done && !result.data_invalid |->
      result.magnitude_gap == ((result.ref1_magnitude >= result.ref2_magnitude) ?
        (result.ref1_magnitude - result.ref2_magnitude) :
        (result.ref2_magnitude - result.ref1_magnitude)))
    else $error("gap does not match the two magnitudes");

endmodule

bind dual_field_magnitude_check dfmc_checker u_dfmc_checker (.*);

// ===== test/dual_field_magnitude_check_tb.sv =====
module dual_field_magnitude_check_tb;
  import dfmc_pkg::*;

  localparam logic [IDX_W-1:0] SPARE_INDEX_LO = 3'd5;
  localparam logic [IDX_W-1:0] SPARE_INDEX_HI = 3'd7;
  localparam logic [MAG_W-1:0] MAG_LIMIT      = {MAG_W{1'b1}};
  localparam logic [1:0]       BOTH_VALID     = 2'b11;
  localparam logic [1:0]       REF1_ONLY      = 2'b01;
  localparam logic [1:0]       REF2_ONLY      = 2'b10;
  localparam logic [1:0]       NONE_VALID     = 2'b00;
  localparam int SETTLE_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 50;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              start    = 1'b0;
  logic              busy;
  sample_t           sample   = '0;
  logic              wr_en    = 1'b0;
  logic [IDX_W-1:0]  wr_index = '0;
  logic [DATA_W-1:0] wr_data  = '0;
  logic              done;
  result_t           result;

  // register shadow for prediction
  logic [SENS_W-1:0] gain_x     = SENS_X_RST;
  logic [SENS_W-1:0] gain_y     = SENS_Y_RST;
  logic [SENS_W-1:0] gain_z     = SENS_Z_RST;
  logic [MAG_W-1:0]  high_limit = HIGH_RST;
  logic [MAG_W-1:0]  gap_limit  = MISM_RST;

  sample_t pending_samples[$];
  result_t expected_results[$];
  int idle_pct     = 0;
  int errors       = 0;
  int quiet_cycles = 0;

  dual_field_magnitude_check i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .sample   (sample),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .done     (done),
    .result   (result)
  );

  always #5 clk = ~clk;

  // |raw| * gain in Q12.12, brought down to 1/16 uT
  function automatic logic [63:0] axis_scaled(input logic signed [RAW_W-1:0] raw,
                                              input logic [SENS_W-1:0] gain);
    longint      v;
    logic [63:0] a;
    v = raw;
    if (v < 0) v = -v;
    a = v;
    return (a * 64'(gain)) >> FRAC_SH;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = MAG_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [MAG_W-1:0] field_strength(input logic signed [RAW_W-1:0] x,
                                                      input logic signed [RAW_W-1:0] y,
                                                      input logic signed [RAW_W-1:0] z);
    logic [63:0] sx, sy, sz, root;
    sx = axis_scaled(x, gain_x);
    sy = axis_scaled(y, gain_y);
    sz = axis_scaled(z, gain_z);
    root = floor_root(sx * sx + sy * sy + sz * sz);
    return (root > 64'(MAG_LIMIT)) ? MAG_LIMIT : root[MAG_W-1:0];
  endfunction

  function automatic result_t field_check(input sample_t s);
    result_t          r;
    logic [MAG_W-1:0] m1, m2;
    r = '0;
    if (s.valid_mask != BOTH_VALID) begin
      r.data_invalid = 1'b1;
      return r;
    end
    m1 = field_strength(s.ref1_x, s.ref1_y, s.ref1_z);
    m2 = field_strength(s.ref2_x, s.ref2_y, s.ref2_z);
    r.ref1_magnitude = m1;
    r.ref2_magnitude = m2;
    r.magnitude_gap  = (m1 >= m2) ? m1 - m2 : m2 - m1;
    r.ref1_high      = (m1 >= high_limit);
    r.ref2_high      = (m2 >= high_limit);
    r.mismatch       = (r.magnitude_gap >= gap_limit);
    return r;
  endfunction

  function automatic sample_t pack_sample(input logic signed [RAW_W-1:0] x1, y1, z1,
                                          input logic signed [RAW_W-1:0] x2, y2, z2,
                                          input logic [1:0] mask);
    sample_t s;
    s.ref1_x = x1;
    s.ref1_y = y1;
    s.ref1_z = z1;
    s.ref2_x = x2;
    s.ref2_y = y2;
    s.ref2_z = z2;
    s.valid_mask = mask;
    return s;
  endfunction

  function automatic logic signed [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      1: return RAW_W'($urandom_range(0, 255)) - 16'sd128;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    case (idx)
      REG_SENS_X:   gain_x     = value[SENS_W-1:0];
      REG_SENS_Y:   gain_y     = value[SENS_W-1:0];
      REG_SENS_Z:   gain_z     = value[SENS_W-1:0];
      REG_HIGH_LIM: high_limit = value[MAG_W-1:0];
      REG_MISM_LIM: gap_limit  = value[MAG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // sender holds off until the pipeline has fully drained
  task automatic wait_idle();
    @(negedge clk);
    while (pending_samples.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [MAG_W-1:0] want,
                             input logic [MAG_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : driver
    if (start && !busy)
      expected_results.push_back(field_check(sample));
    if (!start || !busy) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        sample <= pending_samples.pop_front();
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual %p", $time, result);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("ref1_magnitude", want.ref1_magnitude, result.ref1_magnitude);
        check_field("ref2_magnitude", want.ref2_magnitude, result.ref2_magnitude);
        check_field("magnitude_gap", want.magnitude_gap, result.magnitude_gap);
        check_field("data_invalid", want.data_invalid, result.data_invalid);
        check_field("ref1_high", want.ref1_high, result.ref1_high);
        check_field("ref2_high", want.ref2_high, result.ref2_high);
        check_field("mismatch", want.mismatch, result.mismatch);
      end
    end
    if ((start && !busy) || done || wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    sample_t s;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset register values, field extremes and validity cases
    @(negedge clk);
    pending_samples.push_back(pack_sample(0, 0, 0, 0, 0, 0, BOTH_VALID));
    pending_samples.push_back(pack_sample(32767, 32767, 32767, 32767, 32767, 32767,
                                          BOTH_VALID));
    pending_samples.push_back(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768,
                                          BOTH_VALID));
    pending_samples.push_back(pack_sample(-32768, -32768, -32768, 0, 0, 0, BOTH_VALID));
    pending_samples.push_back(pack_sample(0, 0, 0, 32767, -32768, 32767, BOTH_VALID));
    pending_samples.push_back(pack_sample(-1, 1, -1, 1, -1, 1, BOTH_VALID));
    pending_samples.push_back(pack_sample(32767, 0, 0, 0, 0, 32767, BOTH_VALID));
    pending_samples.push_back(pack_sample(32767, 32767, 32767, 32767, 32767, 32767,
                                          NONE_VALID));
    pending_samples.push_back(pack_sample(-32768, 100, 200, 300, -400, 500, REF1_ONLY));
    pending_samples.push_back(pack_sample(1000, -2000, 3000, -32768, 0, 1, REF2_ONLY));
    pending_samples.push_back(pack_sample(-1, -1, -1, -1, -1, -1, NONE_VALID));
    wait_idle();

    // unit gain so the thresholds can be hit exactly
    write_reg(REG_SENS_X, 4096);
    write_reg(REG_SENS_Y, 4096);
    write_reg(REG_SENS_Z, 4096);
    write_reg(REG_HIGH_LIM, 1000);
    write_reg(REG_MISM_LIM, 500);
    @(negedge clk);
    pending_samples.push_back(pack_sample(1000, 0, 0, 999, 0, 0, BOTH_VALID));
    pending_samples.push_back(pack_sample(0, -999, 0, 0, 0, -1000, BOTH_VALID));
    pending_samples.push_back(pack_sample(1500, 0, 0, 1000, 0, 0, BOTH_VALID));
    pending_samples.push_back(pack_sample(0, 0, 1499, -1000, 0, 0, BOTH_VALID));
    pending_samples.push_back(pack_sample(300, 400, 0, 0, -300, -400, BOTH_VALID));
    pending_samples.push_back(pack_sample(600, 800, 0, 0, 0, 499, BOTH_VALID));
    pending_samples.push_back(pack_sample(600, 800, 0, 0, 0, 500, BOTH_VALID));
    pending_samples.push_back(pack_sample(600, 800, 0, 0, 0, 501, BOTH_VALID));
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_SENS_X, SENS_X_RST);
          write_reg(REG_SENS_Y, SENS_Y_RST);
          write_reg(REG_SENS_Z, SENS_Z_RST);
          write_reg(REG_HIGH_LIM, HIGH_RST);
          write_reg(REG_MISM_LIM, MISM_RST);
        end
        1: begin
          // all ones, sensitivities get masked to their width
          write_reg(REG_SENS_X, MAG_LIMIT);
          write_reg(REG_SENS_Y, MAG_LIMIT);
          write_reg(REG_SENS_Z, MAG_LIMIT);
          write_reg(REG_HIGH_LIM, MAG_LIMIT);
          write_reg(REG_MISM_LIM, MAG_LIMIT);
        end
        2: begin
          write_reg(REG_SENS_X, 0);
          write_reg(REG_SENS_Y, 0);
          write_reg(REG_SENS_Z, 0);
          write_reg(REG_HIGH_LIM, 0);
          write_reg(REG_MISM_LIM, 0);
        end
        default: begin
          write_reg(REG_SENS_X, (p == 3) ? DATA_W'($urandom) :
                    DATA_W'($urandom & ((32'd1 << $urandom_range(8, SENS_W)) - 1)));
          write_reg(REG_SENS_Y, DATA_W'($urandom & ((32'd1 << $urandom_range(8, SENS_W)) - 1)));
          write_reg(REG_SENS_Z, DATA_W'($urandom & ((32'd1 << $urandom_range(8, SENS_W)) - 1)));
          write_reg(REG_HIGH_LIM,
                    DATA_W'($urandom & ((32'd1 << $urandom_range(4, MAG_W)) - 1)));
          write_reg(REG_MISM_LIM,
                    DATA_W'($urandom & ((32'd1 << $urandom_range(4, MAG_W)) - 1)));
          // indexes past the last register must be ignored
          if (p == 3) begin
            write_reg(SPARE_INDEX_LO, MAG_LIMIT);
            write_reg(SPARE_INDEX_HI, DATA_W'($urandom));
          end
        end
      endcase
      @(negedge clk);
      case (p % 4)
        1: idle_pct = 72;
        3: idle_pct = 28;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        s.ref1_x = rand_raw();
        s.ref1_y = rand_raw();
        s.ref1_z = rand_raw();
        if ($urandom_range(0, 2) == 0) begin
          // near-equal pair for small gaps around the mismatch limit
          s.ref2_x = s.ref1_x ^ RAW_W'($urandom_range(0, 7));
          s.ref2_y = s.ref1_y ^ RAW_W'($urandom_range(0, 7));
          s.ref2_z = s.ref1_z ^ RAW_W'($urandom_range(0, 7));
        end else begin
          s.ref2_x = rand_raw();
          s.ref2_y = rand_raw();
          s.ref2_z = rand_raw();
        end
        s.valid_mask = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 2)) : BOTH_VALID;
        pending_samples.push_back(s);
      end
      wait_idle();
    end

    if (errors == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dfmc_pkg.sv
rtl/dual_field_magnitude_check.sv
rtl/dfmc_checker.sv
test/dual_field_magnitude_check_tb.sv
